### hdl/lws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lws_pkg
// shared constants and types of the latency window statistics block
// ----------------------------------------------------------------------------
package lws_pkg;
    localparam int WINDOW_DEPTH = 4096;                  // power of two
    localparam int AW   = $clog2(WINDOW_DEPTH);          // ring address bits
    localparam int CW   = AW + 1;                        // sample count bits
    localparam int SW   = 20;                            // sample bits
    localparam int TW   = 31;                            // tag bits
    localparam int STDW = 24;                            // std dev output bits
    localparam int SUMW = SW + AW;                       // window sum bits
    localparam int SQW  = 2 * SW + AW;                   // squared sum bits
    localparam int QW   = SQW + 8;                       // scaled variance bits
    localparam int RW   = QW / 2;                        // root bits
    localparam int QCW  = $clog2(QW + 1);
    localparam int RCW  = $clog2(RW + 1);
    localparam int INW  = 56;
    localparam int OUTW = 128;

    typedef struct packed {
        logic [SW-1:0] sample;
        logic [CW-1:0] cnt;
        logic [SW-1:0] omax;
        logic [TW-1:0] otag;
    } t_job;
endpackage

### hdl/lws_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lws_ram
// generic single write, single registered read memory
// ----------------------------------------------------------------------------
module lws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/lws_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lws_front
// accepts items, tracks fill level and all-time maximum, queues jobs
// ----------------------------------------------------------------------------
module lws_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [55:0]             i_s_tdata,   // round_trip_us, transfer_tag
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [lws_pkg::CW-1:0]  i_cfg_data,  // window_in_use
    output logic                    o_job_valid,
    input  logic                    i_job_pop,
    output lws_pkg::t_job           o_job
);
    import lws_pkg::*;

    logic [CW-1:0] r_win;
    logic [CW-1:0] r_fill, n_fill;
    logic [SW-1:0] r_omax, n_omax;
    logic [TW-1:0] r_otag, n_otag;
    t_job          r_q [2];
    logic          r_wptr, r_rptr;
    logic [1:0]    r_cnt;
    logic [CW-1:0] win;
    logic [SW-1:0] sample;
    logic [TW-1:0] tag;
    logic          accept;

    assign sample     = i_s_tdata[SW-1:0];
    assign tag        = i_s_tdata[SW+TW-1:SW];
    assign o_s_tready = (r_cnt != 2'd2);
    assign o_cfg_ready = 1'b1;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        if (r_win < CW'(2)) begin
            win = CW'(2);
        end else if (r_win > CW'(WINDOW_DEPTH)) begin
            win = CW'(WINDOW_DEPTH);
        end else begin
            win = r_win;
        end
        n_fill = (r_fill < CW'(WINDOW_DEPTH)) ? r_fill + CW'(1) : r_fill;
        // ties hand the tag to the newer item
        if (sample >= r_omax) begin
            n_omax = sample;
            n_otag = tag;
        end else begin
            n_omax = r_omax;
            n_otag = r_otag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= CW'(WINDOW_DEPTH);
            r_fill <= '0;
            r_omax <= '0;
            r_otag <= '0;
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_win <= i_cfg_data;
            end
            if (accept) begin
                r_fill <= n_fill;
                r_omax <= n_omax;
                r_otag <= n_otag;
                r_wptr <= ~r_wptr;
            end
            if (i_job_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + 2'(accept) - 2'(i_job_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wptr].sample <= sample;
            r_q[r_wptr].cnt    <= (n_fill < win) ? n_fill : win;
            r_q[r_wptr].omax   <= n_omax;
            r_q[r_wptr].otag   <= n_otag;
        end
    end

    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rptr];
endmodule

### hdl/lws_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lws_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lws_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [lws_pkg::QW-1:0] i_dividend,
    input  logic [lws_pkg::CW-1:0] i_divisor,
    output logic                   o_done,
    output logic [lws_pkg::QW-1:0] o_quotient
);
    import lws_pkg::*;

    logic          r_busy;
    logic [QCW-1:0] r_cnt;
    logic [CW-1:0] r_rem;
    logic [CW-1:0] r_dvs;
    logic [QW-1:0] r_quo;
    logic          r_done;
    logic [CW:0]   rem_sh;
    logic          ge;

    assign rem_sh = {r_rem, r_quo[QW-1]};
    assign ge     = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= QCW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - QCW'(1);
                if (r_cnt == QCW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? CW'(rem_sh - {1'b0, r_dvs}) : CW'(rem_sh);
            r_quo <= {r_quo[QW-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

### hdl/lws_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lws_back
// stores each sample; scan and divide twice, root, or once if cnt < 2
// ----------------------------------------------------------------------------
module lws_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_job_valid,
    output logic                     o_job_pop,
    input  lws_pkg::t_job            i_job,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [lws_pkg::OUTW-1:0] o_m_tdata
);
    import lws_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_WRITE = 8'b0000_0010,
        S_SCAN1 = 8'b0000_0100,
        S_DIV1  = 8'b0000_1000,
        S_SCAN2 = 8'b0001_0000,
        S_DIV2  = 8'b0010_0000,
        S_SQRT  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state          r_state;
    t_job            r_job;
    logic [AW-1:0]   r_wp;
    logic [CW-1:0]   r_k;
    logic            r_issue_done;
    logic            r_rd_vld, r_rd_last;
    logic            r_sq_vld, r_sq_last;
    logic [2*SW-1:0] r_sq;
    logic [SUMW-1:0] r_sum;
    logic [SQW-1:0]  r_sqsum;
    logic [SW-1:0]   r_wmax;
    logic [SW-1:0]   r_mean;
    logic [QW-1:0]   r_v, r_res, r_bit;
    logic [RCW-1:0]  r_it;
    logic            r_out_valid;
    logic [OUTW-1:0] r_out;
    logic            div_start, div_done;
    logic [QW-1:0]   div_dividend, div_quo;
    logic [CW-1:0]   div_divisor;
    logic [SW-1:0]   rd_data, diff;
    logic [AW-1:0]   rd_addr;
    logic            issuing, scan, out_free;
    logic [QW-1:0]   trial;

    assign scan     = (r_state == S_SCAN1) || (r_state == S_SCAN2);
    assign issuing  = scan && !r_issue_done;
    assign rd_addr  = r_wp - AW'(1) - r_k[AW-1:0];
    assign diff     = (rd_data >= r_mean) ? rd_data - r_mean : r_mean - rd_data;
    assign trial    = r_res + r_bit;
    assign out_free = !r_out_valid || i_m_tready;
    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;

    lws_ram #(.WIDTH(SW), .DEPTH(WINDOW_DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WRITE),
        .i_waddr (r_wp),
        .i_wdata (r_job.sample),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    lws_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // the divider is started on the cycle the last scan term is summed
    always_comb begin
        div_start    = 1'b0;
        div_dividend = QW'(r_sum + SUMW'(rd_data));
        div_divisor  = r_job.cnt;
        if (r_state == S_SCAN1) begin
            div_start = r_rd_vld && r_rd_last;
        end else if (r_state == S_SCAN2) begin
            div_start    = r_sq_vld && r_sq_last;
            div_dividend = {SQW'(r_sqsum + SQW'(r_sq)), 8'd0};
            div_divisor  = r_job.cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_wp         <= '0;
            r_rd_vld     <= 1'b0;
            r_sq_vld     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_issue_done <= 1'b0;
        end else begin
            r_rd_vld <= issuing;
            r_sq_vld <= r_rd_vld && (r_state == S_SCAN2);
            if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_wp         <= r_wp + AW'(1);
                    r_issue_done <= 1'b0;
                    r_state      <= S_SCAN1;
                end
                S_SCAN1: begin
                    if (issuing && r_k == r_job.cnt - CW'(1)) begin
                        r_issue_done <= 1'b1;
                    end
                    if (div_start) begin
                        r_state <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (div_done) begin
                        r_issue_done <= 1'b0;
                        r_state <= (r_job.cnt < CW'(2)) ? S_DONE : S_SCAN2;
                    end
                end
                S_SCAN2: begin
                    if (issuing && r_k == r_job.cnt - CW'(1)) begin
                        r_issue_done <= 1'b1;
                    end
                    if (div_start) begin
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (div_done) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_it == RCW'(1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_last <= issuing && (r_k == r_job.cnt - CW'(1));
        r_sq_last <= r_rd_last;
        r_sq      <= diff * diff;
        if (o_job_pop) begin
            r_job <= i_job;
        end
        if (issuing) begin
            r_k <= r_k + CW'(1);
        end
        case (r_state)
            S_WRITE: begin
                r_k    <= '0;
                r_sum  <= '0;
                r_wmax <= '0;
            end
            S_SCAN1: begin
                if (r_rd_vld) begin
                    r_sum <= r_sum + SUMW'(rd_data);
                    if (rd_data > r_wmax) begin
                        r_wmax <= rd_data;
                    end
                end
            end
            S_DIV1: begin
                r_k     <= '0;
                r_sqsum <= '0;
                r_mean  <= div_quo[SW-1:0];
            end
            S_SCAN2: begin
                if (r_sq_vld) begin
                    r_sqsum <= r_sqsum + SQW'(r_sq);
                end
            end
            S_DIV2: begin
                r_v   <= div_quo;
                r_res <= '0;
                r_bit <= QW'(1) << (QW - 2);
                r_it  <= RCW'(RW);
            end
            S_SQRT: begin
                // bitwise integer root, two radicand bits per step
                if (r_v >= trial) begin
                    r_v   <= r_v - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_it  <= r_it - RCW'(1);
            end
            S_DONE: begin
                if (out_free) begin
                    r_out <= {r_job.cnt, r_job.otag, r_job.omax,
                              (r_job.cnt < CW'(2)) ? STDW'(0) :
                              ((r_res > QW'({STDW{1'b1}})) ? {STDW{1'b1}} : r_res[STDW-1:0]),
                              r_mean, r_wmax};
                end
            end
            default: begin
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

`ifndef SYNTH
    a_rd_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> scan) else $error("ring read outside a scan");
    a_sq_in_scan2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq_vld |-> (r_state == S_SCAN2)) else $error("square term outside second scan");
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV1 || r_state == S_DIV2))
        else $error("divider finished in wrong state");
    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN1) |-> (r_job.cnt != '0)) else $error("empty window scanned");
`endif
endmodule

### hdl/latency_window_statistics.sv
`timescale 1ns / 1ps
// per item, n = samples_in_window: two ring scans at one read per cycle, two bit-serial
//   divides and a bitwise root (one scan and one divide only when n < 2)
// items are worked one at a time; a two-entry job queue takes items meanwhile
// reset: synchronous active low; clears pointers, fill count and all-time maximum,
//   window register returns to its full depth; ring contents are left as they are
// ----------------------------------------------------------------------------
// latency_window_statistics
// sliding window max, mean and standard deviation of latency samples
// ----------------------------------------------------------------------------
module latency_window_statistics (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [55:0]             i_s_tdata,  // round_trip_us, transfer_tag
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    // window_max, window_mean, window_std_dev_q4, overall_max,
    // overall_max_tag, samples_in_window
    output logic [127:0]            o_m_tdata,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [lws_pkg::CW-1:0]  i_cfg_data  // window_in_use
);
    import lws_pkg::*;

    t_job job;
    logic job_valid, job_pop;

    lws_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_job_valid (job_valid),
        .i_job_pop   (job_pop),
        .o_job       (job)
    );

    lws_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_pop   (job_pop),
        .i_job       (job),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );
endmodule
